/* rtl/core/etp_pkg.sv */
// ----------------------------------------------------------------------------
// etp_pkg
// Shared widths, character codes and keyword table for the elapsed time
// text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package etp_pkg;

  // payload widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned TotalW  = 31;

  // longest days field accepted in front of a dash or blank
  localparam int unsigned MAX_DAY_DIGITS = 5;
  // the leading run must still be able to hold a two digit hours field
  localparam int unsigned LeadMax = (MAX_DAY_DIGITS < 2) ? 2 : MAX_DAY_DIGITS;

  // internal field widths
  localparam int unsigned DayW    = 15;
  localparam int unsigned LeadW   = 17;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned HmsW    = 19;
  localparam int unsigned DaySecW = 32;

  localparam int unsigned DayMax     = 32767;
  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerMin  = 60;

  // character codes
  localparam logic [CharW-1:0] ChrSpace = 8'h20;
  localparam logic [CharW-1:0] ChrTab   = 8'h09;
  localparam logic [CharW-1:0] ChrCr    = 8'h0D;
  localparam logic [CharW-1:0] ChrZero  = 8'h30;
  localparam logic [CharW-1:0] ChrNine  = 8'h39;
  localparam logic [CharW-1:0] ChrColon = 8'h3A;
  localparam logic [CharW-1:0] ChrDash  = 8'h2D;

  localparam int unsigned KwLen = 4;

  // letters of the keyword "days"
  function automatic logic [CharW-1:0] kw_char(input logic [1:0] idx);
    logic [CharW-1:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h64;
      2'd1:    ch = 8'h61;
      2'd2:    ch = 8'h79;
      default: ch = 8'h73;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/etp_char_if.sv */
// ----------------------------------------------------------------------------
// etp_char_if
// Character stream channel: one text character and a last marker per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface etp_char_if;
  logic                        valid;
  logic                        ready;
  logic [etp_pkg::CharW-1:0]   char_code;
  logic                        is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/etp_time_if.sv */
// ----------------------------------------------------------------------------
// etp_time_if
// Result channel: total seconds and status per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface etp_time_if;
  logic                        valid;
  logic                        ready;
  logic [etp_pkg::TotalW-1:0]  total_seconds;
  logic                        status;

  modport source (output valid, output total_seconds, output status, input ready);
  modport sink   (input valid, input total_seconds, input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/elapsed_time_text_parser_core.sv */
// ----------------------------------------------------------------------------
// elapsed_time_text_parser_core
// Parses "D days HH:MM:SS", "D-HH:MM:SS" or "HH:MM:SS" one character at a
// time and returns the total number of seconds.
// ----------------------------------------------------------------------------
// Usage:
//   char_i carries one character per transaction, is_last marks the end of
//   a text. Every character is taken in the cycle it is offered as long as
//   the result pipeline has room, so one character per cycle is sustained.
//   result_o carries exactly one transaction per text: total_seconds and a
//   status bit (1 for bad syntax, incomplete text or overflow, with zero
//   seconds). The parse state sits in registers updated on each accepted
//   character; the last character moves the fields into a three register
//   pipeline (field capture, days multiply, final add and range check).
//   After a last character the parser starts afresh on the next one.
//   When result_o is stalled the pipeline fills; char_i.ready drops only
//   when all three stages hold a result, so up to three texts can finish
//   while the receiver waits.
//   Reset clears the parse state and all valid flags; the block is ready
//   as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module elapsed_time_text_parser_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  etp_char_if.sink       char_i,
  etp_time_if.source     result_o
);

  typedef enum logic [3:0] {
    PH_LEAD_WS,
    PH_LEAD,
    PH_KW_WS,
    PH_KW,
    PH_AFTER_KW,
    PH_HOUR_WS,
    PH_HOUR1,
    PH_COLON1,
    PH_MIN0,
    PH_MIN1,
    PH_COLON2,
    PH_SEC0,
    PH_SEC1,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [etp_pkg::DayW-1:0]   day;
    logic [etp_pkg::FieldW-1:0] hour;
    logic [etp_pkg::FieldW-1:0] minute;
    logic [etp_pkg::FieldW-1:0] second;
    logic                       bad;
  } fields_t;

  // parse state
  phase_e                       phase_q, phase_d;
  logic                         err_q, err_d;
  logic [etp_pkg::DayW-1:0]     day_q, day_d;
  logic [etp_pkg::LeadW-1:0]    lead_q, lead_d;
  logic [etp_pkg::IdxW-1:0]     didx_q, didx_d;
  logic [etp_pkg::IdxW-1:0]     kidx_q, kidx_d;
  logic [etp_pkg::FieldW-1:0]   hour_q, hour_d;
  logic [etp_pkg::FieldW-1:0]   min_q, min_d;
  logic [etp_pkg::FieldW-1:0]   sec_q, sec_d;

  // result pipeline
  logic                         s1_valid_q, s1_valid_d;
  fields_t                      s1_q, s1_d;
  logic                         s1_load;
  logic                         s2_valid_q, s2_valid_d;
  logic [etp_pkg::DaySecW-1:0]  s2_daysec_q;
  logic [etp_pkg::HmsW-1:0]     s2_hms_q;
  logic                         s2_bad_q;
  logic                         out_valid_q, out_valid_d;
  logic [etp_pkg::TotalW-1:0]   out_total_q;
  logic                         out_status_q;

  logic                         out_free, s2_free, s1_free;
  logic                         char_acc;
  logic [etp_pkg::CharW-1:0]    ch;
  logic                         ch_blank, ch_digit;
  logic [3:0]                   digit;
  logic [etp_pkg::LeadW+3:0]    lead_x10;
  logic [etp_pkg::FieldW+3:0]   hour_x10, min_x10, sec_x10;
  logic [etp_pkg::HmsW-1:0]     hms_c;
  logic [etp_pkg::DaySecW:0]    sum_c;
  logic                         status_c;

  assign out_free = !out_valid_q || result_o.ready;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;

  assign char_i.ready = s1_free;
  assign char_acc     = char_i.valid && s1_free;

  assign ch       = char_i.char_code;
  assign ch_blank = (ch == etp_pkg::ChrSpace) || (ch >= etp_pkg::ChrTab && ch <= etp_pkg::ChrCr);
  assign ch_digit = (ch >= etp_pkg::ChrZero) && (ch <= etp_pkg::ChrNine);
  assign digit    = ch[3:0];

  // times ten as shift and add
  assign lead_x10 = {lead_q, 3'b000} + {2'b00, lead_q, 1'b0} + {17'd0, digit};
  assign hour_x10 = {hour_q, 3'b000} + {2'b00, hour_q, 1'b0} + {7'd0, digit};
  assign min_x10  = {min_q, 3'b000} + {2'b00, min_q, 1'b0} + {7'd0, digit};
  assign sec_x10  = {sec_q, 3'b000} + {2'b00, sec_q, 1'b0} + {7'd0, digit};

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    day_d   = day_q;
    lead_d  = lead_q;
    didx_d  = didx_q;
    kidx_d  = kidx_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    s1_load = 1'b0;
    s1_d    = s1_q;

    if (char_acc) begin
      if (!err_q) begin
        unique case (phase_q)
          PH_LEAD_WS: begin
            if (ch_digit) begin
              lead_d  = {13'd0, digit};
              didx_d  = 3'd1;
              phase_d = PH_LEAD;
            end else if (!ch_blank) begin
              err_d = 1'b1;
            end
          end
          PH_LEAD: begin
            if (ch_digit) begin
              if (32'(didx_q) >= etp_pkg::LeadMax) begin
                err_d = 1'b1;
              end else begin
                lead_d = lead_x10[etp_pkg::LeadW-1:0];
                didx_d = didx_q + 3'd1;
              end
            end else if (ch == etp_pkg::ChrColon) begin
              if (didx_q == 3'd2) begin
                hour_d  = lead_q[etp_pkg::FieldW-1:0];
                phase_d = PH_MIN0;
              end else begin
                err_d = 1'b1;
              end
            end else if ((ch == etp_pkg::ChrDash || ch_blank) &&
                         32'(didx_q) <= etp_pkg::MAX_DAY_DIGITS) begin
              if (32'(lead_q) > etp_pkg::DayMax) err_d = 1'b1;
              else day_d = lead_q[etp_pkg::DayW-1:0];
              phase_d = (ch == etp_pkg::ChrDash) ? PH_HOUR_WS : PH_KW_WS;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_KW_WS: begin
            if (ch == etp_pkg::kw_char(2'd0)) begin
              kidx_d  = 3'd1;
              phase_d = PH_KW;
            end else if (!ch_blank) begin
              err_d = 1'b1;
            end
          end
          PH_KW: begin
            if (32'(kidx_q) < etp_pkg::KwLen && ch == etp_pkg::kw_char(kidx_q[1:0])) begin
              kidx_d = kidx_q + 3'd1;
              if (32'(kidx_d) == etp_pkg::KwLen) phase_d = PH_AFTER_KW;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_AFTER_KW: begin
            if (ch_blank) phase_d = PH_HOUR_WS;
            else err_d = 1'b1;
          end
          PH_HOUR_WS: begin
            if (ch_digit) begin
              hour_d  = {3'd0, digit};
              phase_d = PH_HOUR1;
            end else if (!ch_blank) begin
              err_d = 1'b1;
            end
          end
          PH_HOUR1: begin
            if (ch_digit) begin
              hour_d  = hour_x10[etp_pkg::FieldW-1:0];
              phase_d = PH_COLON1;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_COLON1, PH_COLON2: begin
            if (ch == etp_pkg::ChrColon) begin
              phase_d = (phase_q == PH_COLON1) ? PH_MIN0 : PH_SEC0;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_MIN0: begin
            if (ch_digit) begin
              min_d   = {3'd0, digit};
              phase_d = PH_MIN1;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_MIN1: begin
            if (ch_digit) begin
              min_d   = min_x10[etp_pkg::FieldW-1:0];
              phase_d = PH_COLON2;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_SEC0: begin
            if (ch_digit) begin
              sec_d   = {3'd0, digit};
              phase_d = PH_SEC1;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_SEC1: begin
            if (ch_digit) begin
              sec_d   = sec_x10[etp_pkg::FieldW-1:0];
              phase_d = PH_DONE;
            end else begin
              err_d = 1'b1;
            end
          end
          PH_DONE: begin
            // trailing text is ignored
          end
          default: begin
            err_d = 1'b1;
          end
        endcase
      end

      if (char_i.is_last) begin
        s1_load     = 1'b1;
        s1_d.day    = day_d;
        s1_d.hour   = hour_d;
        s1_d.minute = min_d;
        s1_d.second = sec_d;
        s1_d.bad    = err_d || (phase_d != PH_DONE);
        phase_d = PH_LEAD_WS;
        err_d   = 1'b0;
        day_d   = '0;
        lead_d  = '0;
        didx_d  = '0;
        kidx_d  = '0;
        hour_d  = '0;
        min_d   = '0;
        sec_d   = '0;
      end
    end
  end

  // valid flags of the result pipeline
  always_comb begin
    s1_valid_d  = s1_free ? s1_load : s1_valid_q;
    s2_valid_d  = s2_free ? s1_valid_q : s2_valid_q;
    out_valid_d = out_free ? s2_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD_WS;
      err_q       <= 1'b0;
      day_q       <= '0;
      lead_q      <= '0;
      didx_q      <= '0;
      kidx_q      <= '0;
      hour_q      <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      day_q       <= day_d;
      lead_q      <= lead_d;
      didx_q      <= didx_d;
      kidx_q      <= kidx_d;
      hour_q      <= hour_d;
      min_q       <= min_d;
      sec_q       <= sec_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign hms_c = etp_pkg::HmsW'(s1_q.hour) * etp_pkg::HmsW'(etp_pkg::SecPerHour)
               + etp_pkg::HmsW'(s1_q.minute) * etp_pkg::HmsW'(etp_pkg::SecPerMin)
               + etp_pkg::HmsW'(s1_q.second);

  assign sum_c    = {1'b0, s2_daysec_q} + (etp_pkg::DaySecW + 1)'(s2_hms_q);
  // anything at or above 2^31 is out of range
  assign status_c = s2_bad_q || (|sum_c[etp_pkg::DaySecW:etp_pkg::TotalW]);

  always_ff @(posedge clk_i) begin
    if (s1_free && s1_load) begin
      s1_q <= s1_d;
    end
    if (s2_free && s1_valid_q) begin
      s2_daysec_q <= etp_pkg::DaySecW'(s1_q.day) * etp_pkg::DaySecW'(etp_pkg::SecPerDay);
      s2_hms_q    <= hms_c;
      s2_bad_q    <= s1_q.bad;
    end
    if (out_free && s2_valid_q) begin
      out_total_q  <= status_c ? '0 : sum_c[etp_pkg::TotalW-1:0];
      out_status_q <= status_c;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.total_seconds = out_total_q;
  assign result_o.status        = out_status_q;

endmodule

`default_nettype wire

/* bench/tb_elapsed_time_text_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_elapsed_time_text_parser_core
// Self-checking bench for the elapsed time text parser. Texts are sent one
// character per transaction. A short table of hand-made texts comes first,
// then random texts: mostly well-formed keyword, dash and plain forms with
// random fields, plus damaged and noise texts. Each result is checked
// against an in-bench parser model, or against the value typed in the table.
// ----------------------------------------------------------------------------
module tb_elapsed_time_text_parser_core;
  import etp_pkg::*;

  typedef enum logic [3:0] {
    PH_LEAD_WS, PH_LEAD, PH_KW_WS, PH_KW, PH_AFTER_KW, PH_HOUR_WS, PH_HOUR1,
    PH_COLON1, PH_MIN0, PH_MIN1, PH_COLON2, PH_SEC0, PH_SEC1, PH_DONE
  } parse_phase_e;

  typedef struct packed {
    logic [TotalW-1:0] total_seconds;
    logic              status;
  } elapsed_t;

  typedef struct {
    string             text;
    bit                typed;
    logic [TotalW-1:0] total_seconds;
    logic              status;
  } text_row_t;

  localparam logic              STATUS_OK  = 1'b0;
  localparam logic              STATUS_BAD = 1'b1;
  localparam logic [31:0]       KwText     = "days";
  localparam longint unsigned   TotalMax   = 64'h7FFF_FFFF;
  localparam logic [CharW-1:0]  BlankSet [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  localparam int unsigned       SpecialDays [5] = '{24855, 24854, 32767, 32768, 0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  etp_char_if char_ch ();
  etp_time_if time_ch ();

  elapsed_time_text_parser_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_ch),
    .result_o (time_ch)
  );

  // parser model state
  parse_phase_e         phase;
  bit                   err_seen;
  logic [DayW-1:0]      days;
  logic [LeadW-1:0]     lead;
  logic [IdxW-1:0]      ndig;
  logic [IdxW-1:0]      kwi;
  logic [FieldW-1:0]    hh;
  logic [FieldW-1:0]    mm;
  logic [FieldW-1:0]    ss;

  elapsed_t             pending_times[$];
  elapsed_t             want;
  logic [CharW-1:0]     text_buf[$];
  string                near_chars = "0123456789:- days";
  int unsigned          mismatches = 0;
  int unsigned          chars_sent = 0;
  int                   hold_left  = 0;
  bit                   gaps_on    = 1'b1;

  function automatic void clear_parse();
    phase    = PH_LEAD_WS;
    err_seen = 1'b0;
    days     = '0;
    lead     = '0;
    ndig     = '0;
    kwi      = '0;
    hh       = '0;
    mm       = '0;
    ss       = '0;
  endfunction

  function automatic bit is_blank(input logic [CharW-1:0] c);
    return c == ChrSpace || (c >= ChrTab && c <= ChrCr);
  endfunction

  function automatic bit is_digit(input logic [CharW-1:0] c);
    return c >= ChrZero && c <= ChrNine;
  endfunction

  function automatic logic [CharW-1:0] kw_letter(input logic [IdxW-1:0] i);
    return KwText[31 - 8*i -: 8];
  endfunction

  function automatic void take_days();
    if (lead > DayMax) err_seen = 1'b1;
    else days = lead[DayW-1:0];
  endfunction

  function automatic void parse_char(input logic [CharW-1:0] c);
    logic [3:0] d;
    d = 4'(c - ChrZero);
    if (err_seen) return;
    case (phase)
      PH_LEAD_WS: begin
        if (is_digit(c)) begin
          lead  = LeadW'(d);
          ndig  = 1;
          phase = PH_LEAD;
        end else if (!is_blank(c)) begin
          err_seen = 1'b1;
        end
      end
      PH_LEAD: begin
        if (is_digit(c)) begin
          if (ndig >= LeadMax) begin
            err_seen = 1'b1;
          end else begin
            lead = LeadW'(lead * 10 + d);
            ndig = ndig + 1'b1;
          end
        end else if (c == ChrColon) begin
          if (ndig == 2) begin
            hh    = lead[FieldW-1:0];
            phase = PH_MIN0;
          end else begin
            err_seen = 1'b1;
          end
        end else if (c == ChrDash && ndig <= MAX_DAY_DIGITS) begin
          take_days();
          phase = PH_HOUR_WS;
        end else if (is_blank(c) && ndig <= MAX_DAY_DIGITS) begin
          take_days();
          phase = PH_KW_WS;
        end else begin
          err_seen = 1'b1;
        end
      end
      PH_KW_WS: begin
        if (c == kw_letter(0)) begin
          kwi   = 1;
          phase = PH_KW;
        end else if (!is_blank(c)) begin
          err_seen = 1'b1;
        end
      end
      PH_KW: begin
        if (kwi < KwLen && c == kw_letter(kwi)) begin
          kwi = kwi + 1'b1;
          if (kwi == KwLen) phase = PH_AFTER_KW;
        end else begin
          err_seen = 1'b1;
        end
      end
      PH_AFTER_KW: begin
        if (is_blank(c)) phase = PH_HOUR_WS;
        else err_seen = 1'b1;
      end
      PH_HOUR_WS: begin
        if (is_digit(c)) begin
          hh    = FieldW'(d);
          phase = PH_HOUR1;
        end else if (!is_blank(c)) begin
          err_seen = 1'b1;
        end
      end
      PH_COLON1, PH_COLON2: begin
        if (c == ChrColon) phase = parse_phase_e'(phase + 1'b1);
        else err_seen = 1'b1;
      end
      PH_HOUR1, PH_MIN0, PH_MIN1, PH_SEC0, PH_SEC1: begin
        if (!is_digit(c)) begin
          err_seen = 1'b1;
        end else begin
          case (phase)
            PH_HOUR1: hh = FieldW'(hh * 10 + d);
            PH_MIN0:  mm = FieldW'(d);
            PH_MIN1:  mm = FieldW'(mm * 10 + d);
            PH_SEC0:  ss = FieldW'(d);
            default:  ss = FieldW'(ss * 10 + d);
          endcase
          phase = parse_phase_e'(phase + 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the character ends a text, with the parsed time in r
  function automatic bit elapsed_step(input logic [CharW-1:0] c, input logic last,
                                      output elapsed_t r);
    longint unsigned sum;
    logic            bad;
    r = '0;
    parse_char(c);
    if (!last) return 1'b0;
    bad = err_seen || phase != PH_DONE;
    sum = 64'(days) * SecPerDay + 64'(hh) * SecPerHour + 64'(mm) * SecPerMin + 64'(ss);
    if (!bad && sum > TotalMax) bad = 1'b1;
    r.status        = bad ? STATUS_BAD : STATUS_OK;
    r.total_seconds = bad ? '0 : sum[TotalW-1:0];
    clear_parse();
    return 1'b1;
  endfunction

  // random text building
  function automatic void put_blanks(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) text_buf.push_back(BlankSet[$urandom_range(5, 0)]);
  endfunction

  function automatic void put_digits(input int n);
    repeat (n) text_buf.push_back(ChrZero + CharW'($urandom_range(9, 0)));
  endfunction

  function automatic void put_days();
    string s;
    if ($urandom_range(3, 0) == 0) begin
      s = $sformatf("%0d", SpecialDays[$urandom_range(4, 0)]);
      for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    end else begin
      put_digits(($urandom_range(19, 0) == 0) ? 6 : $urandom_range(MAX_DAY_DIGITS, 1));
    end
  endfunction

  function automatic void put_clock();
    put_digits(2);
    text_buf.push_back(ChrColon);
    put_digits(2);
    text_buf.push_back(ChrColon);
    put_digits(2);
  endfunction

  function automatic void make_random_text();
    int roll;
    int cut;
    roll = $urandom_range(99, 0);
    text_buf.delete();
    if (roll < 10) begin
      repeat ($urandom_range(14, 1)) begin
        if ($urandom_range(1, 0) != 0) text_buf.push_back(CharW'($urandom_range(255, 0)));
        else text_buf.push_back(near_chars[$urandom_range(near_chars.len() - 1, 0)]);
      end
      return;
    end
    if ($urandom_range(2, 0) == 0) put_blanks(1, 3);
    case ($urandom_range(2, 0))
      0: begin
        put_days();
        put_blanks(1, 2);
        for (int k = 0; k < KwLen; k++) text_buf.push_back(kw_letter(k));
        put_blanks(1, 2);
        put_clock();
      end
      1: begin
        put_days();
        text_buf.push_back(ChrDash);
        if ($urandom_range(2, 0) == 0) put_blanks(1, 2);
        put_clock();
      end
      default: put_clock();
    endcase
    if ($urandom_range(4, 0) == 0)
      repeat ($urandom_range(3, 1)) text_buf.push_back(CharW'($urandom_range(255, 0)));
    // broken sequences: a corrupted character or a text cut short
    if (roll < 25) begin
      if ($urandom_range(1, 0) != 0) begin
        text_buf[$urandom_range(text_buf.size() - 1, 0)] = CharW'($urandom_range(255, 0));
      end else begin
        cut = $urandom_range(text_buf.size() - 1, 1);
        while (text_buf.size() > cut) void'(text_buf.pop_back());
      end
    end
  endfunction

  // send text_buf, one character per transaction, last flag on the final one
  task automatic send_text(input bit typed, input elapsed_t typed_res);
    elapsed_t r;
    bit       ends;
    for (int i = 0; i < text_buf.size(); i++) begin
      while (gaps_on && $urandom_range(99, 0) < 25) begin
        char_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
      char_ch.valid     <= 1'b1;
      char_ch.char_code <= text_buf[i];
      char_ch.is_last   <= (i == text_buf.size() - 1);
      do @(posedge clk_i); while (!char_ch.ready);
      ends = elapsed_step(text_buf[i], i == text_buf.size() - 1, r);
      if (ends) pending_times.push_back(typed ? typed_res : r);
      chars_sent++;
      @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    char_ch.valid <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && time_ch.valid && time_ch.ready) begin
      if (pending_times.size() == 0) begin
        $error("unexpected result transaction: total_seconds %0d status %0d",
               time_ch.total_seconds, time_ch.status);
        mismatches++;
      end else begin
        want = pending_times.pop_front();
        if (time_ch.total_seconds !== want.total_seconds) begin
          $error("total_seconds: expected %0d, actual %0d", want.total_seconds,
                 time_ch.total_seconds);
          mismatches++;
        end
        if (time_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, time_ch.status);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    time_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        time_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        time_ch.ready <= !(gaps_on && $urandom_range(99, 0) < 25);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_elapsed_time_text_parser_core: FAIL");
    $finish;
  end

  initial begin
    text_row_t rows[$];
    elapsed_t  typed_res;
    string     s;
    bit        held;
    bit        paused;
    held   = 1'b0;
    paused = 1'b0;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    char_ch.is_last   = 1'b0;
    clear_parse();

    rows = '{
      '{"00:00:00",                      1'b1, 31'd0,          STATUS_OK},
      '{"99:99:99",                      1'b1, 31'd362439,     STATUS_OK},
      '{"24855 days 03:14:07",           1'b1, 31'd2147483647, STATUS_OK},
      '{"24855-03:14:08",                1'b1, 31'd0,          STATUS_BAD},
      '{"32767 days 99:99:99",           1'b1, 31'd0,          STATUS_BAD},
      '{"32768-00:00:00",                1'b1, 31'd0,          STATUS_BAD},
      '{"123456-00:00:00",               1'b1, 31'd0,          STATUS_BAD},
      '{"00000-00:00:00",                1'b1, 31'd0,          STATUS_OK},
      '{" \t\n\013\014\015 1 days 01:02:03", 1'b0, 31'd0,      STATUS_OK},
      '{"7-\t 12:34:56 trailing",        1'b0, 31'd0,          STATUS_OK},
      '{"42 \t days\015\n00:59:59",      1'b0, 31'd0,          STATUS_OK},
      '{"12-34:56:78",                   1'b0, 31'd0,          STATUS_OK},
      '{"5 dayz 00:00:00",               1'b1, 31'd0,          STATUS_BAD},
      '{"5days 00:00:00",                1'b1, 31'd0,          STATUS_BAD},
      '{"1 days01:00:00",                1'b1, 31'd0,          STATUS_BAD},
      '{"123:00:00",                     1'b1, 31'd0,          STATUS_BAD},
      '{"1:00:00",                       1'b1, 31'd0,          STATUS_BAD},
      '{"12:3a:00",                      1'b1, 31'd0,          STATUS_BAD},
      '{"12:34",                         1'b1, 31'd0,          STATUS_BAD},
      '{"9",                             1'b1, 31'd0,          STATUS_BAD},
      '{"x",                             1'b1, 31'd0,          STATUS_BAD},
      '{"01:02:03",                      1'b1, 31'd3723,       STATUS_OK}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[r]) begin
      text_buf.delete();
      s = rows[r].text;
      for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
      typed_res.total_seconds = rows[r].total_seconds;
      typed_res.status        = rows[r].status;
      send_text(rows[r].typed, typed_res);
    end
    drain_results();

    while (chars_sent < 1950) begin
      // a stretch with no idling on either side
      gaps_on = !(chars_sent >= 600 && chars_sent < 900);
      if (!held && chars_sent >= 1000) begin
        hold_left = 200;
        held      = 1'b1;
      end
      if (!paused && chars_sent >= 1400) begin
        drain_results();
        paused = 1'b1;
      end
      make_random_text();
      send_text(1'b0, '0);
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_times.size() == 0) begin
      $display("tb_elapsed_time_text_parser_core: PASS");
    end else begin
      $display("tb_elapsed_time_text_parser_core: FAIL");
    end
    $finish;
  end

endmodule
